// ===== hw/rtl/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg
// Shared constants, types and constant tables of the chime tone synthesiser.
// ----------------------------------------------------------------------------
package cts_pkg;

	localparam int PITCH_COUNT     = 5;
	localparam int PENDING_DEPTH   = 4;
	localparam int SINE_TABLE_BITS = 10;
	localparam int PHASE_BITS      = 32;

	localparam int PARTIALS    = 3;
	localparam int SEL_W       = 3;
	localparam int CNT_W       = $clog2(PENDING_DEPTH + 1);
	localparam int IDX_W       = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int SR_W     = 18;
	localparam int MS_W     = 10;
	localparam int ATK_W    = 25;
	localparam int DEC_W    = 24;
	localparam int GAIN_W   = 15;
	localparam int PITCH_W  = 15;
	localparam int SAMPLE_W = 16;
	localparam int FRAME_W  = 18;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 25;

	localparam int DEN_W  = 28;
	localparam int DIV_W  = PHASE_BITS + 24;
	localparam int MUL_W  = 32;
	localparam int PROD_W = 64;
	localparam int TONE_W = 33;
	localparam int MAG_W  = 31;
	localparam int ENV_W  = 25;
	localparam int QSUM_W = 24;

	// Division of the frame product by 1000 as a reciprocal multiplication.
	localparam logic [MUL_W-1:0]   LEN_RECIP  = 32'd274877907;
	localparam int                 LEN_SHIFT  = 38;

	localparam logic [FRAME_W-1:0] MAX_FRAMES = {FRAME_W{1'b1}};
	localparam logic [DEN_W-1:0]   MS_PER_S   = DEN_W'(1000);
	localparam logic [ATK_W-1:0]   ONE_Q24    = ATK_W'(1) << 24;
	localparam logic [DEC_W-1:0]   DECAY_FULL = {DEC_W{1'b1}};

	localparam int QBITS = SINE_TABLE_BITS - 2;
	localparam int QTR   = 1 << QBITS;

	typedef struct packed {
		logic [SR_W-1:0]   sample_rate;
		logic [MS_W-1:0]   length_ms;
		logic [ATK_W-1:0]  attack_step;
		logic [DEC_W-1:0]  decay_factor;
		logic [GAIN_W-1:0] output_gain;
	} cfg_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_SAMPLE_RATE,
		CFG_LENGTH_MS,
		CFG_ATTACK_STEP,
		CFG_DECAY_FACTOR,
		CFG_OUTPUT_GAIN
	} cfg_idx_t;

	typedef enum logic {
		CMD_TICK,
		CMD_PLAY
	} cmd_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [SEL_W-1:0] sel;
	} item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LEN_MUL,
		ST_LEN_DIV,
		ST_LEN_WAIT,
		ST_Q_MUL,
		ST_Q_CHK,
		ST_DEN_MUL,
		ST_DEN_REG,
		ST_NUM_MUL,
		ST_INC_DIV,
		ST_INC_WAIT,
		ST_START,
		ST_T_SIN,
		ST_T_MUL,
		ST_T_ACC,
		ST_T_ENV,
		ST_T_ENVR,
		ST_T_M1,
		ST_T_M1R,
		ST_T_M2,
		ST_T_OUT,
		ST_T_DEC,
		ST_T_UPD,
		ST_EMIT,
		ST_POP
	} state_t;

	function automatic logic [10:0] pitch_of(input logic [SEL_W-1:0] sel);
		case (sel)
			3'd0: return 11'd1640;
			3'd1: return 11'd1710;
			3'd2: return 11'd1780;
			3'd3: return 11'd1840;
			default: return 11'd1870;
		endcase
	endfunction

	function automatic logic [11:0] ratio_of(input logic [1:0] k);
		case (k)
			2'd0: return 12'd1000;
			2'd1: return 12'd1487;
			default: return 12'd2319;
		endcase
	endfunction

	function automatic logic [14:0] weight_of(input logic [1:0] k);
		case (k)
			2'd0: return 15'd18022;
			2'd1: return 15'd9175;
			default: return 15'd5571;
		endcase
	endfunction

	function automatic logic [PHASE_BITS-1:0] offset_of(input logic [1:0] k);
		logic [31:0] full;
		case (k)
			2'd0: full = 32'd0;
			2'd1: full = 32'd211905235;
			default: full = 32'd526345262;
		endcase
		full = full >> (32 - PHASE_BITS);
		return full[PHASE_BITS-1:0];
	endfunction

	// Quarter-wave sine in Q15 from an odd polynomial, rounded and capped.
	function automatic logic [14:0] sine_calc(input int unsigned pos);
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		u  = 64'(pos) << (30 - QBITS);
		u2 = (u * u) >> 30;
		t  = 64'd85566056 - ((u2 * 64'd5018337) >> 30);
		t  = 64'd693598242 - ((u2 * t) >> 30);
		t  = 64'd1686629713 - ((u2 * t) >> 30);
		s  = (u * t) >> 30;
		v  = (s + 64'd16384) >> 15;
		if (v > 64'd32767)
			v = 64'd32767;
		return v[14:0];
	endfunction

	typedef logic [14:0] qtr_tab_t [QTR];

	function automatic qtr_tab_t build_qtr();
		qtr_tab_t tab;
		for (int i = 0; i < QTR; i++)
			tab[i] = sine_calc(i);
		return tab;
	endfunction

	localparam qtr_tab_t    SINE_QTR  = build_qtr();
	localparam logic [14:0] SINE_PEAK = sine_calc(QTR);

endpackage

// ===== hw/rtl/chime_tone_synthesizer_unit.sv =====
// ----------------------------------------------------------------------------
// chime_tone_synthesizer_unit
// Three-partial chime synthesiser with attack and decay envelope.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                     tuser         tlast
// s_        in   [14:0] pitch_hz           cmd           -
// m_        out  [15:0] sample             playing       chime_done
// cfg_      in   we, addr (register), wdata (up to 25 bits)
//
// During a chime, the back runs a sample beat through the steps of the three
// partials and the envelope on the shared multiplier; while idle it sends a
// sample beat straight to the output. A play beat that starts a chime runs
// the three divisions for the phase increments, and so does a sample beat
// that ends a chime with one pending. A beat passes the front register and
// then the queue before the back sees it.
// Reset clears all control state; the result register holds a beat under stall
// while the front and its queue go on taking beats until the queue fills.
module chime_tone_synthesizer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,   // [14:0] pitch_hz
	input  logic                           s_tuser,   // [0] cmd
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [cts_pkg::SAMPLE_W-1:0]   m_tdata,   // [15:0] sample
	output logic                           m_tuser,   // [0] playing
	output logic                           m_tlast,
	input  logic                           cfg_we,
	input  logic [cts_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [cts_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import cts_pkg::*;

	cfg_t  cfg_q;
	logic  f_valid;
	logic  f_ready;
	item_t f_item;
	logic  b_valid;
	logic  b_ready;
	item_t b_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_rate  <= SR_W'(48000);
			cfg_q.length_ms    <= MS_W'(115);
			cfg_q.attack_step  <= ATK_W'(332049);
			cfg_q.decay_factor <= DEC_W'(16766384);
			cfg_q.output_gain  <= GAIN_W'(5200);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_SAMPLE_RATE:  cfg_q.sample_rate  <= cfg_wdata[SR_W-1:0];
				CFG_LENGTH_MS:    cfg_q.length_ms    <= cfg_wdata[MS_W-1:0];
				CFG_ATTACK_STEP:  cfg_q.attack_step  <= cfg_wdata[ATK_W-1:0];
				CFG_DECAY_FACTOR: cfg_q.decay_factor <= cfg_wdata[DEC_W-1:0];
				CFG_OUTPUT_GAIN:  cfg_q.output_gain  <= cfg_wdata[GAIN_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	cts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser),
		.in_pitch   (s_tdata[PITCH_W-1:0]),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	cts_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_item  (b_item)
	);

	cts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_valid  (b_valid),
		.item_ready  (b_ready),
		.item        (b_item),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_sample  (m_tdata),
		.out_playing (m_tuser),
		.out_done    (m_tlast)
	);

endmodule

// ===== hw/rtl/cts_front.sv =====
// ----------------------------------------------------------------------------
// cts_front
// Takes command beats, picks the nearest chime pitch and hands items on.
// ----------------------------------------------------------------------------
module cts_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_cmd,
	input  logic [cts_pkg::PITCH_W-1:0] in_pitch,
	output logic                        item_valid,
	input  logic                        item_ready,
	output cts_pkg::item_t              item
);
	import cts_pkg::*;

	logic             valid_s1;
	item_t            item_s1;
	logic [SEL_W-1:0] sel;
	logic [PITCH_W-1:0] best_d;
	logic [PITCH_W-1:0] d;
	logic [PITCH_W-1:0] ref_p;

	always_comb begin
		ref_p  = PITCH_W'(pitch_of('0));
		best_d = (ref_p > in_pitch) ? ref_p - in_pitch : in_pitch - ref_p;
		sel    = '0;
		d      = best_d;
		for (int i = 1; i < PITCH_COUNT; i++) begin
			ref_p = PITCH_W'(pitch_of(SEL_W'(i)));
			d     = (ref_p > in_pitch) ? ref_p - in_pitch : in_pitch - ref_p;
			if (d < best_d) begin
				best_d = d;
				sel    = SEL_W'(i);
			end
		end
	end

	assign in_ready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.cmd <= in_cmd ? CMD_PLAY : CMD_TICK;
			item_s1.sel <= sel;
		end
	end

endmodule

// ===== hw/rtl/cts_fifo.sv =====
// ----------------------------------------------------------------------------
// cts_fifo
// Short item queue between the front and the back of the synthesiser.
// ----------------------------------------------------------------------------
module cts_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cts_pkg::item_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output cts_pkg::item_t out_item
);
	import cts_pkg::*;

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wptr_q;
	logic [QPTR_W-1:0]  rptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               pop;

	assign in_ready  = count_q != QCNT_W'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_item  = mem_q[rptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= in_item;
	end

endmodule

// ===== hw/rtl/cts_div.sv =====
// ----------------------------------------------------------------------------
// cts_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cts_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [cts_pkg::DIV_W-1:0] dividend,
	input  logic [cts_pkg::DEN_W-1:0] divisor,
	output logic                      done,
	output logic [cts_pkg::DIV_W-1:0] quotient
);
	import cts_pkg::*;

	localparam int CNT_BITS = $clog2(DIV_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DEN_W-1:0]    rem_q;
	logic [DIV_W-1:0]    quo_q;
	logic [DEN_W-1:0]    dsr_q;
	logic [DEN_W:0]      rem_sh;
	logic [DEN_W:0]      diff;
	logic                ge;

	assign rem_sh   = {rem_q, quo_q[DIV_W-1]};
	assign ge       = rem_sh >= {1'b0, dsr_q};
	assign diff     = rem_sh - {1'b0, dsr_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_BITS'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

endmodule

// ===== hw/rtl/cts_back.sv =====
// ----------------------------------------------------------------------------
// cts_back
// Sequencer that runs play and tick items over a shared multiplier and divider.
// ----------------------------------------------------------------------------
module cts_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cts_pkg::cfg_t                cfg,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  cts_pkg::item_t               item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [cts_pkg::SAMPLE_W-1:0] out_sample,
	output logic                         out_playing,
	output logic                         out_done
);
	import cts_pkg::*;

	state_t state_q;
	state_t state_d;

	logic                   active_q;
	logic                   pop_q;
	logic [1:0]             k_q;
	logic [CNT_W-1:0]       pend_cnt_q;
	logic [SEL_W-1:0]       pend_q [PENDING_DEPTH];
	logic [SEL_W-1:0]       sel_q;
	logic [FRAME_W-1:0]     frames_q;
	logic [DEN_W-1:0]       den_q;
	logic [PHASE_BITS-1:0]  phase_q [PARTIALS];
	logic [PHASE_BITS-1:0]  inc_q [PARTIALS];
	logic [ATK_W-1:0]       attack_q;
	logic [DEC_W-1:0]       decay_q;
	logic [FRAME_W-1:0]     frame_q;
	logic [FRAME_W-1:0]     chime_frames_q;
	logic [14:0]            sin_q;
	logic                   sin_neg_q;
	logic signed [TONE_W-1:0] tone_q;
	logic [MAG_W-1:0]       mag_q;
	logic [ENV_W-1:0]       env_q;
	logic [MAG_W-1:0]       m1_q;
	logic [PROD_W-1:0]      prod_q;
	logic [SAMPLE_W-1:0]    res_sample_q;
	logic                   res_play_q;
	logic                   res_done_q;
	logic                   out_valid_q;
	logic [SAMPLE_W-1:0]    out_sample_q;
	logic                   out_play_q;
	logic                   out_done_q;

	logic [MUL_W-1:0]       mul_a;
	logic [MUL_W-1:0]       mul_b;
	logic                   div_start;
	logic [DIV_W-1:0]       div_dividend;
	logic [DEN_W-1:0]       div_divisor;
	logic                   div_done;
	logic [DIV_W-1:0]       div_quo;

	logic                   take;
	logic                   emit_fire;
	logic [FRAME_W-1:0]     frames_w;
	logic [FRAME_W-1:0]     left_w;
	logic [QSUM_W-1:0]      queued_w;
	logic                   drop_w;
	logic                   push_w;
	logic                   done_w;
	logic                   last_k;
	logic                   sr_zero;
	logic [PHASE_BITS-1:0]  phase_sel;
	logic [SINE_TABLE_BITS-1:0] sidx;
	logic [QBITS-1:0]       sr_r;
	logic [QBITS-1:0]       sr_mir;
	logic [14:0]            sin_w;
	logic [PROD_W-1:0]      rnd23;
	logic [PROD_W-1:0]      rnd29;
	logic [17:0]            m2_w;
	logic [17:0]            cap_w;
	logic [17:0]            m2c_w;
	logic [17:0]            m2n_w;
	logic                   neg_w;
	logic [ATK_W:0]         atk_sum;

	cts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign take      = (state_q == ST_IDLE) && item_valid;
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign last_k    = k_q == 2'(PARTIALS - 1);
	assign sr_zero   = cfg.sample_rate == '0;

	assign frames_w = (prod_q[PROD_W-1:LEN_SHIFT+FRAME_W] != '0) ? MAX_FRAMES
		: prod_q[LEN_SHIFT+FRAME_W-1:LEN_SHIFT];
	assign left_w   = (chime_frames_q > frame_q) ? chime_frames_q - frame_q : '0;
	assign queued_w = QSUM_W'(left_w) + prod_q[QSUM_W-1:0];
	assign drop_w   = active_q && (queued_w > QSUM_W'(cfg.sample_rate >> 3));
	assign push_w   = (frames_q != '0) && active_q && !drop_w
		&& (pend_cnt_q < CNT_W'(PENDING_DEPTH));
	assign done_w   = ({1'b0, frame_q} + 1'b1) >= {1'b0, chime_frames_q};

	assign phase_sel = phase_q[k_q];
	assign sidx      = phase_sel[PHASE_BITS-1 -: SINE_TABLE_BITS];
	assign sr_r      = sidx[QBITS-1:0];
	assign sr_mir    = -sr_r;

	always_comb begin
		if (sidx[QBITS]) begin
			sin_w = (sr_r == '0) ? SINE_PEAK : SINE_QTR[sr_mir];
		end else begin
			sin_w = SINE_QTR[sr_r];
		end
	end

	assign rnd23   = prod_q + (PROD_W'(1) << 23);
	assign rnd29   = prod_q + (PROD_W'(1) << 29);
	assign m2_w    = rnd29[47:30];
	assign neg_w   = tone_q[TONE_W-1];
	assign cap_w   = neg_w ? 18'd32768 : 18'd32767;
	assign m2c_w   = (m2_w > cap_w) ? cap_w : m2_w;
	assign m2n_w   = -m2c_w;
	assign atk_sum = {1'b0, attack_q} + {1'b0, cfg.attack_step};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (item.cmd == CMD_PLAY)
						state_d = ST_LEN_MUL;
					else if (active_q)
						state_d = ST_T_SIN;
					else
						state_d = ST_EMIT;
				end
			end
			ST_LEN_MUL: state_d = ST_LEN_DIV;
			ST_LEN_DIV: state_d = ST_LEN_WAIT;
			ST_LEN_WAIT: begin
				if (!pop_q)
					state_d = ST_Q_MUL;
				else if (frames_w == '0)
					state_d = ST_IDLE;
				else
					state_d = ST_DEN_MUL;
			end
			ST_Q_MUL: state_d = ST_Q_CHK;
			ST_Q_CHK: begin
				if (frames_q == '0)
					state_d = ST_IDLE;
				else if (!active_q || drop_w)
					state_d = ST_DEN_MUL;
				else
					state_d = ST_IDLE;
			end
			ST_DEN_MUL: state_d = ST_DEN_REG;
			ST_DEN_REG: state_d = ST_NUM_MUL;
			ST_NUM_MUL: state_d = ST_INC_DIV;
			ST_INC_DIV: begin
				if (!sr_zero)
					state_d = ST_INC_WAIT;
				else if (last_k)
					state_d = ST_START;
				else
					state_d = ST_NUM_MUL;
			end
			ST_INC_WAIT: begin
				if (div_done)
					state_d = last_k ? ST_START : ST_NUM_MUL;
			end
			ST_START: state_d = ST_IDLE;
			ST_T_SIN: state_d = ST_T_MUL;
			ST_T_MUL: state_d = ST_T_ACC;
			ST_T_ACC: state_d = last_k ? ST_T_ENV : ST_T_SIN;
			ST_T_ENV: state_d = ST_T_ENVR;
			ST_T_ENVR: state_d = ST_T_M1;
			ST_T_M1: state_d = ST_T_M1R;
			ST_T_M1R: state_d = ST_T_M2;
			ST_T_M2: state_d = ST_T_OUT;
			ST_T_OUT: state_d = ST_T_DEC;
			ST_T_DEC: state_d = ST_T_UPD;
			ST_T_UPD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_fire)
					state_d = (res_done_q && pend_cnt_q != '0) ? ST_POP : ST_IDLE;
			end
			ST_POP: state_d = ST_LEN_MUL;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready   = state_q == ST_IDLE;
		mul_a        = '0;
		mul_b        = '0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			ST_LEN_MUL: begin
				mul_a = MUL_W'(cfg.sample_rate);
				mul_b = MUL_W'(cfg.length_ms);
			end
			ST_LEN_DIV: begin
				mul_a = MUL_W'(prod_q[DEN_W-1:0]);
				mul_b = LEN_RECIP;
			end
			ST_Q_MUL: begin
				mul_a = MUL_W'(pend_cnt_q);
				mul_b = MUL_W'(frames_q);
			end
			ST_DEN_MUL: begin
				mul_a = MUL_W'(cfg.sample_rate);
				mul_b = MUL_W'(MS_PER_S);
			end
			ST_NUM_MUL: begin
				mul_a = MUL_W'(pitch_of(sel_q));
				mul_b = MUL_W'(ratio_of(k_q));
			end
			ST_INC_DIV: begin
				div_start    = !sr_zero;
				div_dividend = (DIV_W'(prod_q[22:0]) << PHASE_BITS)
					+ DIV_W'(den_q[DEN_W-1:1]);
				div_divisor  = den_q;
			end
			ST_T_MUL: begin
				mul_a = MUL_W'(weight_of(k_q));
				mul_b = MUL_W'(sin_q);
			end
			ST_T_ENV: begin
				mul_a = MUL_W'(attack_q);
				mul_b = MUL_W'(decay_q);
			end
			ST_T_M1: begin
				mul_a = MUL_W'(mag_q);
				mul_b = MUL_W'(env_q);
			end
			ST_T_M2: begin
				mul_a = MUL_W'(m1_q);
				mul_b = MUL_W'(cfg.output_gain);
			end
			ST_T_DEC: begin
				mul_a = MUL_W'(decay_q);
				mul_b = MUL_W'(cfg.decay_factor);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			pop_q       <= 1'b0;
			k_q         <= '0;
			pend_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						pop_q <= 1'b0;
						k_q   <= '0;
					end
				end
				ST_POP: begin
					pop_q      <= 1'b1;
					pend_cnt_q <= pend_cnt_q - 1'b1;
				end
				ST_LEN_WAIT: begin
					if (pop_q && frames_w == '0)
						pend_cnt_q <= '0;
				end
				ST_Q_CHK: begin
					if (drop_w) begin
						active_q   <= 1'b0;
						pend_cnt_q <= '0;
					end else if (push_w) begin
						pend_cnt_q <= pend_cnt_q + 1'b1;
					end
				end
				ST_DEN_MUL: k_q <= '0;
				ST_INC_DIV: begin
					if (sr_zero)
						k_q <= k_q + 1'b1;
				end
				ST_INC_WAIT: begin
					if (div_done)
						k_q <= k_q + 1'b1;
				end
				ST_START: active_q <= 1'b1;
				ST_T_ACC: k_q <= k_q + 1'b1;
				ST_T_UPD: begin
					if (done_w)
						active_q <= 1'b0;
				end
				default: begin
					pop_q <= pop_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (emit_fire) begin
			out_sample_q <= res_sample_q;
			out_play_q   <= res_play_q;
			out_done_q   <= res_done_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					sel_q        <= item.sel;
					tone_q       <= '0;
					res_sample_q <= '0;
					res_play_q   <= 1'b0;
					res_done_q   <= 1'b0;
				end
			end
			ST_POP: begin
				sel_q <= pend_q[0];
				for (int i = 0; i < PENDING_DEPTH - 1; i++)
					pend_q[i] <= pend_q[i+1];
			end
			ST_LEN_WAIT: frames_q <= frames_w;
			ST_Q_CHK: begin
				for (int i = 0; i < PENDING_DEPTH; i++) begin
					if (push_w && pend_cnt_q[IDX_W-1:0] == IDX_W'(i))
						pend_q[i] <= sel_q;
				end
			end
			ST_DEN_REG: den_q <= prod_q[DEN_W-1:0];
			ST_INC_DIV: begin
				if (sr_zero)
					inc_q[k_q] <= '0;
			end
			ST_INC_WAIT: begin
				if (div_done)
					inc_q[k_q] <= div_quo[PHASE_BITS-1:0];
			end
			ST_START: begin
				for (int i = 0; i < PARTIALS; i++)
					phase_q[i] <= offset_of(2'(i));
				attack_q       <= '0;
				decay_q        <= DECAY_FULL;
				frame_q        <= '0;
				chime_frames_q <= frames_q;
			end
			ST_T_SIN: begin
				sin_q     <= sin_w;
				sin_neg_q <= sidx[SINE_TABLE_BITS-1];
			end
			ST_T_ACC: begin
				if (sin_neg_q)
					tone_q <= tone_q - TONE_W'(prod_q[29:0]);
				else
					tone_q <= tone_q + TONE_W'(prod_q[29:0]);
			end
			ST_T_ENVR: begin
				env_q <= rnd23[48:24];
				mag_q <= neg_w ? MAG_W'(-tone_q) : MAG_W'(tone_q);
			end
			ST_T_M1R: m1_q <= rnd23[54:24];
			ST_T_OUT: begin
				res_sample_q <= neg_w ? m2n_w[SAMPLE_W-1:0] : m2c_w[SAMPLE_W-1:0];
				res_play_q   <= 1'b1;
				res_done_q   <= done_w;
			end
			ST_T_UPD: begin
				decay_q <= rnd23[47:24];
				for (int i = 0; i < PARTIALS; i++)
					phase_q[i] <= phase_q[i] + inc_q[i];
				attack_q <= (atk_sum > {1'b0, ONE_Q24}) ? ONE_Q24 : atk_sum[ATK_W-1:0];
				frame_q  <= frame_q + 1'b1;
			end
			default: begin
				sel_q <= sel_q;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign out_sample  = out_sample_q;
	assign out_playing = out_play_q;
	assign out_done    = out_done_q;

endmodule

// ===== tb/chime_tone_synthesizer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// chime_tone_synthesizer_unit_tb
// Self-checking testbench for the chime tone synthesiser. Play and tick beats
// are driven under several register settings. A scoreboard predicts every
// sample beat in fixed point and compares it field by field with the output.
// ----------------------------------------------------------------------------
module chime_tone_synthesizer_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import cts_pkg::*;

	typedef struct {
		logic [15:0] sample;
		bit          playing;
		bit          done;
	} frame_t;

	class chime_scoreboard;
		int unsigned sample_rate, length_ms, attack_step, decay_factor, output_gain;
		bit [31:0]   phase [3];
		bit [31:0]   incr [3];
		int unsigned attack_lvl, decay_lvl, frame_idx, frames;
		bit          active;
		bit [2:0]    pending [$];
		frame_t      sample_q [$];
		int unsigned errors, samples, chimes_done;

		function void reset_state();
			sample_rate = 48000;
			length_ms = 115;
			attack_step = 332049;
			decay_factor = 16766384;
			output_gain = 5200;
			foreach (phase[k]) begin
				phase[k] = 0;
				incr[k] = 0;
			end
			attack_lvl = 0;
			decay_lvl = 24'hFFFFFF;
			frame_idx = 0;
			frames = 0;
			active = 0;
			pending.delete();
		endfunction

		function void write_reg(cfg_idx_t idx, int unsigned val);
			case (idx)
				CFG_SAMPLE_RATE:  sample_rate = val & 18'h3FFFF;
				CFG_LENGTH_MS:    length_ms = val & 10'h3FF;
				CFG_ATTACK_STEP:  attack_step = val & 25'h1FFFFFF;
				CFG_DECAY_FACTOR: decay_factor = val & 24'hFFFFFF;
				CFG_OUTPUT_GAIN:  output_gain = val & 15'h7FFF;
				default: ;
			endcase
		endfunction

		function int unsigned pitch_hz(int unsigned sel);
			case (sel)
				0: return 1640;
				1: return 1710;
				2: return 1780;
				3: return 1840;
				default: return 1870;
			endcase
		endfunction

		function int unsigned chime_length();
			longint unsigned f;
			f = longint'(sample_rate) * length_ms / 1000;
			return (f > 18'h3FFFF) ? 18'h3FFFF : int'(f);
		endfunction

		function int signed sine_q15(int unsigned idx);
			int unsigned q, r;
			bit [63:0] u, u2, t, s, v;
			q = (idx >> 8) & 3;
			r = idx & 255;
			u = ((q & 1) ? 64'(256 - r) : 64'(r)) << 22;
			u2 = (u * u) >> 30;
			t = 64'd85566056 - ((u2 * 64'd5018337) >> 30);
			t = 64'd693598242 - ((u2 * t) >> 30);
			t = 64'd1686629713 - ((u2 * t) >> 30);
			s = (u * t) >> 30;
			v = (s + 64'd16384) >> 15;
			if (v > 32767)
				v = 32767;
			return (q & 2) ? -int'(v) : int'(v);
		endfunction

		function void start_chime(int unsigned sel, int unsigned len);
			bit [63:0] num, den;
			int unsigned ratio [3] = '{1000, 1487, 2319};
			bit [31:0] offs [3] = '{32'd0, 32'd211905235, 32'd526345262};
			for (int k = 0; k < 3; k++) begin
				incr[k] = 0;
				if (sample_rate != 0) begin
					den = 64'(sample_rate) * 1000;
					num = (64'(pitch_hz(sel)) * ratio[k]) << 32;
					incr[k] = 32'((num + den / 2) / den);
				end
				phase[k] = offs[k];
			end
			attack_lvl = 0;
			decay_lvl = 24'hFFFFFF;
			frame_idx = 0;
			frames = len;
			active = 1;
		endfunction

		function void note_beat(cmd_t cmd, int unsigned pitch);
			int unsigned sel, di, ds, len;
			longint unsigned left, queued;
			longint signed tone;
			longint unsigned env, mag, m1, m2, cap, a;
			int signed w [3] = '{18022, 9175, 5571};
			bit neg;
			frame_t f;
			if (cmd == CMD_PLAY) begin
				sel = 0;
				for (int i = 1; i < 5; i++) begin
					di = (pitch_hz(i) > pitch) ? pitch_hz(i) - pitch : pitch - pitch_hz(i);
					ds = (pitch_hz(sel) > pitch) ? pitch_hz(sel) - pitch : pitch - pitch_hz(sel);
					if (di < ds)
						sel = i;
				end
				len = chime_length();
				if (active) begin
					left = (frames > frame_idx) ? frames - frame_idx : 0;
					queued = left + longint'(pending.size()) * len;
					if (queued > sample_rate / 8) begin
						active = 0;
						pending.delete();
					end
				end
				if (len == 0)
					return;
				if (!active)
					start_chime(sel, len);
				else if (pending.size() < PENDING_DEPTH)
					pending.push_back(sel[2:0]);
				return;
			end
			if (!active) begin
				f.sample = 0;
				f.playing = 0;
				f.done = 0;
				sample_q.push_back(f);
				return;
			end
			tone = 0;
			for (int k = 0; k < 3; k++)
				tone += longint'(w[k]) * sine_q15(phase[k] >> 22);
			env = (longint'(attack_lvl) * decay_lvl + (1 << 23)) >> 24;
			neg = tone < 0;
			mag = neg ? -tone : tone;
			m1 = (mag * env + (1 << 23)) >> 24;
			m2 = (m1 * output_gain + (1 << 29)) >> 30;
			cap = neg ? 32768 : 32767;
			if (m2 > cap)
				m2 = cap;
			f.sample = neg ? 16'(17'h10000 - m2) : 16'(m2);
			f.playing = 1;
			f.done = (frame_idx + 1 >= frames);
			sample_q.push_back(f);
			for (int k = 0; k < 3; k++)
				phase[k] = phase[k] + incr[k];
			a = longint'(attack_lvl) + attack_step;
			attack_lvl = (a > (1 << 24)) ? (1 << 24) : int'(a);
			decay_lvl = int'((longint'(decay_lvl) * decay_factor + (1 << 23)) >> 24);
			frame_idx = (frame_idx + 1) & 18'h3FFFF;
			if (f.done) begin
				active = 0;
				if (pending.size() > 0) begin
					sel = pending.pop_front();
					len = chime_length();
					if (len == 0)
						pending.delete();
					else
						start_chime(sel, len);
				end
			end
		endfunction

		function void check_sample(logic [15:0] sample, logic playing, logic done);
			frame_t f;
			if (sample_q.size() == 0) begin
				$error("sample beat with nothing expected: sample %h", sample);
				errors++;
				return;
			end
			f = sample_q.pop_front();
			samples++;
			if (done)
				chimes_done++;
			if (sample !== f.sample) begin
				$error("sample: expected %h, got %h", f.sample, sample);
				errors++;
			end
			if (playing !== f.playing) begin
				$error("playing: expected %b, got %b", f.playing, playing);
				errors++;
			end
			if (done !== f.done) begin
				$error("chime_done: expected %b, got %b", f.done, done);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	chime_scoreboard sb;
	bit          quiet;
	bit          hold_req;
	int unsigned beats_sent;

	chime_tone_synthesizer_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_sample(m_tdata, m_tuser, m_tlast);
	end

	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 0;
				hold_req = 0;
				repeat (600) @(negedge clk);
				m_tready <= 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				m_tready <= 1;
			end else begin
				m_tready <= 1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_beat(cmd_t cmd, int unsigned pitch);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {1'b0, pitch[14:0]};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_beat(cmd, pitch & 15'h7FFF);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int unsigned val);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= CFG_DATA_W'(val);
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	// Waits until every sample is out and every play still in the block has
	// finished, so that register writes never meet work in flight.
	task automatic settle();
		s_tvalid <= 0;
		while (sb.sample_q.size() != 0)
			@(negedge clk);
		repeat (2000) @(negedge clk);
	endtask

	task automatic set_config(int unsigned sr, int unsigned ms, int unsigned atk,
			int unsigned dec, int unsigned gain);
		write_reg(CFG_SAMPLE_RATE, sr);
		write_reg(CFG_LENGTH_MS, ms);
		write_reg(CFG_ATTACK_STEP, atk);
		write_reg(CFG_DECAY_FACTOR, dec);
		write_reg(CFG_OUTPUT_GAIN, gain);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	function automatic int unsigned pick_pitch();
		int unsigned near [5] = '{1640, 1710, 1780, 1840, 1870};
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 32767);
			1: return $urandom_range(0, 24000);
			default: return near[$urandom_range(0, 4)] + $urandom_range(0, 80) - 40;
		endcase
	endfunction

	task automatic random_phase(int unsigned count, int unsigned play_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < play_pct)
				send_beat(CMD_PLAY, pick_pitch());
			else
				send_beat(CMD_TICK, $urandom_range(0, 32767));
		end
	endtask

	initial begin
		int unsigned srs [7] = '{8000, 8000, 16000, 48000, 192000, 262143, 0};
		int unsigned mss [6] = '{1, 2, 3, 6, 125, 1000};
		int unsigned atks [5] = '{0, 1, 332049, 16777216, 33554431};
		int unsigned decs [4] = '{0, 16766384, 16777215, 12000000};
		int unsigned gains [4] = '{0, 1, 5200, 32767};
		sb = new();
		sb.reset_state();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		cfg_we = 0;
		cfg_addr = 0;
		cfg_wdata = 0;
		quiet = 0;
		hold_req = 0;
		beats_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_beat(CMD_TICK, 0);
		send_beat(CMD_PLAY, 0);
		send_beat(CMD_TICK, 32767);
		send_beat(CMD_PLAY, 24000);
		send_beat(CMD_PLAY, 1675);
		send_beat(CMD_TICK, 0);
		send_beat(CMD_PLAY, 32767);
		send_beat(CMD_TICK, 0);
		settle();

		set_config(8000, 2, 16777216, 16777215, 32767);
		send_beat(CMD_PLAY, 1640);
		send_beat(CMD_PLAY, 1710);
		send_beat(CMD_PLAY, 1780);
		send_beat(CMD_PLAY, 1840);
		send_beat(CMD_PLAY, 1870);
		send_beat(CMD_PLAY, 1745);
		for (int i = 0; i < 10; i++)
			send_beat(CMD_TICK, 0);
		settle();

		set_config(8000, 3, 2000000, 16000000, 20000);
		hold_req = 1;
		send_beat(CMD_PLAY, 1810);
		random_phase(60, 10);
		settle();

		set_config(8000, 125, 332049, 16766384, 5200);
		random_phase(60, 30);
		settle();

		for (int p = 0; p < 8; p++) begin
			set_config(srs[$urandom_range(0, 6)], mss[$urandom_range(0, 5)],
				atks[$urandom_range(0, 4)], decs[$urandom_range(0, 3)],
				gains[$urandom_range(0, 3)]);
			random_phase(70, 20);
			settle();
		end

		quiet = 1;
		set_config(16000, 1, 4000000, 16700000, 32767);
		random_phase(70, 25);
		settle();

		$display("Beats sent: %0d, sample beats checked: %0d, chime ends seen: %0d.",
			beats_sent, sb.samples, sb.chimes_done);
		if (sb.errors == 0 && sb.sample_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== chime_tone_synthesizer_unit.f =====
hw/rtl/cts_pkg.sv
hw/rtl/cts_front.sv
hw/rtl/cts_fifo.sv
hw/rtl/cts_div.sv
hw/rtl/cts_back.sv
hw/rtl/chime_tone_synthesizer_unit.sv
tb/chime_tone_synthesizer_unit_tb.sv
